@@ hdl/llrs_pkg.sv @@
// ----------------------------------------------------------------------------
// llrs_pkg: shared types and constants for the automaton row step
// Rule thresholds, neighbor bit bundle, result beat layout and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package llrs_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 4096;

  localparam int ROW_W     = 64;
  localparam int COLS_W    = 7;
  localparam int ROWS_W    = 13;
  localparam int THR_W     = 4;
  localparam int INDEX_W   = 12;
  localparam int EXT_W     = 17;
  localparam int OUT_TDATA_W = 208;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [COLS_W-1:0] GRID_COLS_RST   = 7'd64;
  localparam logic [ROWS_W-1:0] GRID_ROWS_RST   = 13'd64;
  localparam logic [THR_W-1:0]  UNDER_LIMIT_RST = 4'd2;
  localparam logic [THR_W-1:0]  OVER_LIMIT_RST  = 4'd3;
  localparam logic [THR_W-1:0]  BIRTH_COUNT_RST = 4'd3;

  typedef enum logic [2:0] {
    REG_GRID_COLS   = 3'd0,
    REG_GRID_ROWS   = 3'd1,
    REG_UNDER_LIMIT = 3'd2,
    REG_OVER_LIMIT  = 3'd3,
    REG_BIRTH_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] under_limit;
    logic [THR_W-1:0] over_limit;
    logic [THR_W-1:0] birth_count;
  } rule_t;

  typedef struct packed {
    logic up;
    logic mid;
    logic cur;
  } nbr_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic               last_of_frame;
    logic [INDEX_W-1:0] row_index;
    logic [ROW_W-1:0]   died_mask;
    logic [ROW_W-1:0]   born_mask;
    logic [ROW_W-1:0]   next_row;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/llrs_cell.sv @@
// ----------------------------------------------------------------------------
// llrs_cell: one column of the automaton
// Holds the column's bits of the two rows above, trades them with its
// neighbors and forms the column's next state for both candidate results.
// ----------------------------------------------------------------------------
`default_nettype none

module llrs_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  in_bit,
  input  llrs_pkg::cell_ctl_t  ctl,
  input  llrs_pkg::rule_t      rule,
  input  llrs_pkg::nbr_t       left,
  input  llrs_pkg::nbr_t       right,
  output llrs_pkg::nbr_t       own,
  output logic                 next_a,
  output logic                 born_a,
  output logic                 died_a,
  output logic                 next_b,
  output logic                 born_b,
  output logic                 died_b
);

  logic upper;
  logic middle;
  logic [3:0] cnt_a;
  logic [3:0] cnt_b;
  logic alive_a;
  logic alive_b;

  function automatic logic apply_rule(input logic [3:0] n, input logic cur,
                                      input llrs_pkg::rule_t r);
    logic res;
    if (n < r.under_limit) res = 1'b0;
    else if (n > r.over_limit) res = 1'b0;
    else if (n == r.birth_count) res = 1'b1;
    else res = cur;
    return res;
  endfunction

  assign own.up  = en & upper;
  assign own.mid = en & middle;
  assign own.cur = en & in_bit;

  always_comb begin
    cnt_a = 4'(left.up) + 4'(own.up) + 4'(right.up)
          + 4'(left.mid) + 4'(right.mid)
          + 4'(left.cur) + 4'(own.cur) + 4'(right.cur);
    cnt_b = 4'(left.mid) + 4'(own.mid) + 4'(right.mid)
          + 4'(left.cur) + 4'(right.cur);
    alive_a = en & apply_rule(cnt_a, own.mid, rule);
    alive_b = en & apply_rule(cnt_b, own.cur, rule);
  end

  assign next_a = alive_a;
  assign born_a = alive_a & ~own.mid;
  assign died_a = own.mid & ~alive_a;
  assign next_b = alive_b;
  assign born_b = alive_b & ~own.cur;
  assign died_b = own.cur & ~alive_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (ctl.load) begin
      if (ctl.clear) begin
        upper  <= 1'b0;
        middle <= 1'b0;
      end else begin
        upper  <= own.mid;
        middle <= own.cur;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/llrs_out_queue.sv @@
// ----------------------------------------------------------------------------
// llrs_out_queue: result beat queue
// Four-entry queue that takes up to two result beats per cycle and hands
// one beat per cycle to the output stream while it is ready to take one.
// ----------------------------------------------------------------------------
`default_nettype none

module llrs_out_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push_a,
  input  wire                 push_b,
  input  llrs_pkg::res_t      res_a,
  input  llrs_pkg::res_t      res_b,
  input  wire                 pop,
  output llrs_pkg::res_t      head,
  output logic                not_empty,
  output logic                has_room,
  output logic [2:0]          level
);

  llrs_pkg::res_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr_next;
  logic [2:0] level_next;
  logic do_pop;

  assign do_pop    = pop & not_empty;
  assign not_empty = (level != 3'd0);
  assign has_room  = (level <= 3'd2);
  assign head      = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + 2'(push_a) + 2'(push_b);
    level_next  = level + 3'(push_a) + 3'(push_b) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) slots[wr_ptr] <= res_a;
    if (push_b) begin
      if (push_a) slots[wr_ptr + 2'd1] <= res_b;
      else slots[wr_ptr] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      level  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/life_like_automaton_row_step.sv @@
// ----------------------------------------------------------------------------
// life_like_automaton_row_step: one generation of a life-like automaton
// Order: a row's result beat is queued at the edge that accepts the row
//   below it (the last row's beat at its own edge) and is shown from the registered queue.
// Throughput: one row per cycle while the four-entry output queue has room.
// Reset clears the stored rows, the row count and the queue; registers take
//   their defaults (64 columns, 64 rows, limits 2 and 3, birth at 3).
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_row_step #(
  parameter int MAX_COLS = llrs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = llrs_pkg::MAX_ROWS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [llrs_pkg::ADDR_W-1:0]          paddr,
  input  wire  [llrs_pkg::DATA_W-1:0]          pwdata,
  output logic [llrs_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // row_cells[63:0]
  input  wire  [llrs_pkg::ROW_W-1:0]           s_tdata,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // next_row[63:0], born_mask[127:64], died_mask[191:128], row_index[203:192]
  output logic [llrs_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // last_of_frame
  output logic                                 m_tlast
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [llrs_pkg::COLS_W-1:0] grid_cols;
  logic [llrs_pkg::ROWS_W-1:0] grid_rows;
  llrs_pkg::rule_t             rule;
  logic [RW-1:0]               rows_seen;
  logic [RW-1:0]               rows_seen_next;

  logic [llrs_pkg::COLS_W-1:0] eff_cols;
  logic [llrs_pkg::EXT_W-1:0]  eff_rows;
  logic [llrs_pkg::EXT_W-1:0]  seen_plus;
  logic                        last_row;
  logic                        in_fire;
  logic                        cfg_wr;
  llrs_pkg::reg_idx_t          cfg_idx;
  llrs_pkg::cell_ctl_t         ctl;

  logic [MAX_COLS-1:0] col_en;
  llrs_pkg::nbr_t      own [MAX_COLS];
  logic [MAX_COLS-1:0] next_a, born_a, died_a, next_b, born_b, died_b;

  llrs_pkg::res_t res_a;
  llrs_pkg::res_t res_b;
  llrs_pkg::res_t head;
  logic           push_a;
  logic           has_room;
  logic [2:0]     level;
  logic [31:0]    idx_cur;
  logic [31:0]    idx_prev;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = llrs_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols        <= llrs_pkg::GRID_COLS_RST;
      grid_rows        <= llrs_pkg::GRID_ROWS_RST;
      rule.under_limit <= llrs_pkg::UNDER_LIMIT_RST;
      rule.over_limit  <= llrs_pkg::OVER_LIMIT_RST;
      rule.birth_count <= llrs_pkg::BIRTH_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        llrs_pkg::REG_GRID_COLS:   grid_cols <= pwdata[llrs_pkg::COLS_W-1:0];
        llrs_pkg::REG_GRID_ROWS:   grid_rows <= pwdata[llrs_pkg::ROWS_W-1:0];
        llrs_pkg::REG_UNDER_LIMIT: rule.under_limit <= pwdata[llrs_pkg::THR_W-1:0];
        llrs_pkg::REG_OVER_LIMIT:  rule.over_limit <= pwdata[llrs_pkg::THR_W-1:0];
        llrs_pkg::REG_BIRTH_COUNT: rule.birth_count <= pwdata[llrs_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      llrs_pkg::REG_GRID_COLS:   prdata = 32'(grid_cols);
      llrs_pkg::REG_GRID_ROWS:   prdata = 32'(grid_rows);
      llrs_pkg::REG_UNDER_LIMIT: prdata = 32'(rule.under_limit);
      llrs_pkg::REG_OVER_LIMIT:  prdata = 32'(rule.over_limit);
      llrs_pkg::REG_BIRTH_COUNT: prdata = 32'(rule.birth_count);
      default:                   prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (grid_cols == '0) eff_cols = llrs_pkg::COLS_W'(1);
    else if (grid_cols > llrs_pkg::COLS_W'(MAX_COLS)) eff_cols = llrs_pkg::COLS_W'(MAX_COLS);
    else eff_cols = grid_cols;
    if (grid_rows == '0) eff_rows = llrs_pkg::EXT_W'(1);
    else if (llrs_pkg::EXT_W'(grid_rows) > llrs_pkg::EXT_W'(MAX_ROWS))
      eff_rows = llrs_pkg::EXT_W'(MAX_ROWS);
    else eff_rows = llrs_pkg::EXT_W'(grid_rows);
    seen_plus = llrs_pkg::EXT_W'(rows_seen) + llrs_pkg::EXT_W'(1);
    last_row  = (seen_plus >= eff_rows);
    rows_seen_next = last_row ? '0 : RW'(seen_plus);
  end

  assign s_tready  = has_room;
  assign in_fire   = s_tvalid & s_tready;
  assign ctl.load  = in_fire;
  assign ctl.clear = last_row;

  always_ff @(posedge clk) begin
    if (rst) rows_seen <= '0;
    else if (in_fire) rows_seen <= rows_seen_next;
  end

  genvar c;
  generate
    for (c = 0; c < MAX_COLS; c++) begin : g_col
      llrs_pkg::nbr_t left_n;
      llrs_pkg::nbr_t right_n;
      assign col_en[c] = (llrs_pkg::COLS_W'(c) < eff_cols);
      if (c == 0) begin : g_l0
        assign left_n = '0;
      end else begin : g_l
        assign left_n = own[c-1];
      end
      if (c == MAX_COLS - 1) begin : g_r0
        assign right_n = '0;
      end else begin : g_r
        assign right_n = own[c+1];
      end
      llrs_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .en     (col_en[c]),
        .in_bit (s_tdata[c]),
        .ctl    (ctl),
        .rule   (rule),
        .left   (left_n),
        .right  (right_n),
        .own    (own[c]),
        .next_a (next_a[c]),
        .born_a (born_a[c]),
        .died_a (died_a[c]),
        .next_b (next_b[c]),
        .born_b (born_b[c]),
        .died_b (died_b[c])
      );
    end
  endgenerate

  always_comb begin
    idx_cur  = 32'(rows_seen);
    idx_prev = idx_cur - 32'd1;
    res_a.next_row      = llrs_pkg::ROW_W'(next_a);
    res_a.born_mask     = llrs_pkg::ROW_W'(born_a);
    res_a.died_mask     = llrs_pkg::ROW_W'(died_a);
    res_a.row_index     = idx_prev[llrs_pkg::INDEX_W-1:0];
    res_a.last_of_frame = 1'b0;
    res_b.next_row      = llrs_pkg::ROW_W'(next_b);
    res_b.born_mask     = llrs_pkg::ROW_W'(born_b);
    res_b.died_mask     = llrs_pkg::ROW_W'(died_b);
    res_b.row_index     = idx_cur[llrs_pkg::INDEX_W-1:0];
    res_b.last_of_frame = 1'b1;
  end

  assign push_a = in_fire & (rows_seen != '0);

  llrs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .push_b    (in_fire & last_row),
    .res_a     (res_a),
    .res_b     (res_b),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .has_room  (has_room),
    .level     (level)
  );

  assign m_tdata = {4'd0, head.row_index, head.died_mask, head.born_mask, head.next_row};
  assign m_tlast = head.last_of_frame;

  a_level_max: assert property (@(posedge clk) disable iff (rst) level <= 3'd4)
    else $error("result queue overflow");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_row |=> rows_seen == '0)
    else $error("row count not cleared after last row");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_row |=> rows_seen == $past(rows_seen) + RW'(1))
    else $error("row count did not advance");

  a_masks_apart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((head.born_mask & head.died_mask) == '0) &&
                 ((head.born_mask & ~head.next_row) == '0))
    else $error("born and died masks inconsistent");

endmodule

`default_nettype wire

@@ dv/tb_life_like_automaton_row_step.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_like_automaton_row_step: row-stream testbench for the automaton step
// Streams grid rows into the block and configures its rules over the register
// port. A local next-generation model tracks the row window and queues the
// expected result beats, which are compared field by field as they arrive.
// A short directed table runs first, then random frames under random rules,
// with random gaps on the row side and random stalls on the result side.
// ----------------------------------------------------------------------------

module tb_life_like_automaton_row_step;

  localparam int ITEMS       = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  typedef enum logic {STIM_ROW, STIM_CFG} stim_kind_t;

  typedef struct packed {
    logic                       on;
    logic [llrs_pkg::ROW_W-1:0] next_row;
    logic [llrs_pkg::ROW_W-1:0] born_mask;
    logic [llrs_pkg::ROW_W-1:0] died_mask;
  } typed_res_t;

  typedef struct packed {
    stim_kind_t                 kind;
    llrs_pkg::reg_idx_t         idx;
    logic [31:0]                val;
    logic [llrs_pkg::ROW_W-1:0] cells;
    typed_res_t                 res;
  } stim_t;

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [llrs_pkg::ADDR_W-1:0]      paddr;
  logic [llrs_pkg::DATA_W-1:0]      pwdata;
  logic [llrs_pkg::DATA_W-1:0]      prdata;
  logic                             pready;
  logic                             s_tvalid;
  logic                             s_tready;
  // row_cells[63:0]
  logic [llrs_pkg::ROW_W-1:0]       s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  // next_row[63:0], born_mask[127:64], died_mask[191:128], row_index[203:192]
  logic [llrs_pkg::OUT_TDATA_W-1:0] m_tdata;
  // last_of_frame
  logic                             m_tlast;

  // rule registers and row window of the local model
  logic [llrs_pkg::COLS_W-1:0] cols_cfg;
  logic [llrs_pkg::ROWS_W-1:0] rows_cfg;
  logic [llrs_pkg::THR_W-1:0]  under_thr;
  logic [llrs_pkg::THR_W-1:0]  over_thr;
  logic [llrs_pkg::THR_W-1:0]  birth_thr;
  logic [llrs_pkg::ROW_W-1:0]  upper_q;
  logic [llrs_pkg::ROW_W-1:0]  middle_q;
  int                          rows_in;

  llrs_pkg::res_t next_gen_q[$];
  typed_res_t     typed_q[$];
  stim_t          dir_tab[$];
  int             fail_cnt;
  int             rows_sent;
  bit             tx_idle;
  bit             rx_idle;
  int unsigned    cycle_cnt;

  life_like_automaton_row_step DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, next_gen_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [llrs_pkg::ROW_W-1:0] col_mask_of(
      logic [llrs_pkg::COLS_W-1:0] cols);
    if (cols == 0) return 64'd1;
    if (cols >= llrs_pkg::MAX_COLS_DEF) return '1;
    return (64'd1 << cols) - 64'd1;
  endfunction

  function automatic llrs_pkg::res_t life_row(logic [llrs_pkg::ROW_W-1:0] above,
                                              logic [llrs_pkg::ROW_W-1:0] cur,
                                              logic [llrs_pkg::ROW_W-1:0] below,
                                              logic [llrs_pkg::ROW_W-1:0] mask,
                                              int idx, logic last);
    logic [llrs_pkg::ROW_W+1:0] a;
    logic [llrs_pkg::ROW_W+1:0] m;
    logic [llrs_pkg::ROW_W+1:0] b;
    logic [llrs_pkg::ROW_W-1:0] nxt;
    logic                       alive;
    int                         n;
    llrs_pkg::res_t             r;
    a = {1'b0, above & mask, 1'b0};
    m = {1'b0, cur & mask, 1'b0};
    b = {1'b0, below & mask, 1'b0};
    nxt = '0;
    for (int c = 0; c < llrs_pkg::ROW_W; c++) begin
      n = a[c] + a[c+1] + a[c+2] + m[c] + m[c+2] + b[c] + b[c+1] + b[c+2];
      if (n < under_thr) alive = 1'b0;
      else if (n > over_thr) alive = 1'b0;
      else if (n == birth_thr) alive = 1'b1;
      else alive = m[c+1];
      nxt[c] = alive;
    end
    nxt = nxt & mask;
    r.next_row      = nxt;
    r.born_mask     = nxt & ~(cur & mask);
    r.died_mask     = (cur & mask) & ~nxt;
    r.row_index     = llrs_pkg::INDEX_W'(idx);
    r.last_of_frame = last;
    return r;
  endfunction

  task automatic advance_generation(logic [llrs_pkg::ROW_W-1:0] cells);
    logic [llrs_pkg::ROW_W-1:0] mask;
    logic [llrs_pkg::ROW_W-1:0] row;
    int                         rows_lim;
    bit                         last;
    typed_res_t                 tr;
    mask = col_mask_of(cols_cfg);
    row = cells & mask;
    rows_lim = (rows_cfg == 0) ? 1 :
               ((rows_cfg > llrs_pkg::MAX_ROWS_DEF) ? llrs_pkg::MAX_ROWS_DEF
                                                   : int'(rows_cfg));
    last = (rows_in + 1 >= rows_lim);
    if (rows_in > 0)
      next_gen_q.push_back(life_row(upper_q, middle_q, row, mask, rows_in - 1, 1'b0));
    if (last) begin
      next_gen_q.push_back(life_row((rows_in > 0) ? middle_q : '0, row, '0, mask, rows_in, 1'b1));
      upper_q = '0;
      middle_q = '0;
      rows_in = 0;
    end else begin
      upper_q = (rows_in > 0) ? middle_q : '0;
      middle_q = row;
      rows_in++;
    end
    if (typed_q.size() != 0) begin
      tr = typed_q.pop_front();
      if (tr.on) begin
        next_gen_q[$].next_row  = tr.next_row;
        next_gen_q[$].born_mask = tr.born_mask;
        next_gen_q[$].died_mask = tr.died_mask;
      end
    end
  endtask

  task automatic check_val(string what, logic [llrs_pkg::ROW_W-1:0] want,
                           logic [llrs_pkg::ROW_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : model_and_check
    llrs_pkg::res_t want;
    if (rst) begin
      cols_cfg  = llrs_pkg::GRID_COLS_RST;
      rows_cfg  = llrs_pkg::GRID_ROWS_RST;
      under_thr = llrs_pkg::UNDER_LIMIT_RST;
      over_thr  = llrs_pkg::OVER_LIMIT_RST;
      birth_thr = llrs_pkg::BIRTH_COUNT_RST;
      upper_q   = '0;
      middle_q  = '0;
      rows_in   = 0;
      next_gen_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (llrs_pkg::reg_idx_t'(paddr[4:2]))
          llrs_pkg::REG_GRID_COLS:   cols_cfg  = pwdata[llrs_pkg::COLS_W-1:0];
          llrs_pkg::REG_GRID_ROWS:   rows_cfg  = pwdata[llrs_pkg::ROWS_W-1:0];
          llrs_pkg::REG_UNDER_LIMIT: under_thr = pwdata[llrs_pkg::THR_W-1:0];
          llrs_pkg::REG_OVER_LIMIT:  over_thr  = pwdata[llrs_pkg::THR_W-1:0];
          llrs_pkg::REG_BIRTH_COUNT: birth_thr = pwdata[llrs_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        advance_generation(s_tdata);
      if (m_tvalid && m_tready) begin
        if (next_gen_q.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected beat: expected none actual row_index %0d",
                   $time, m_tdata[203:192]);
        end else begin
          want = next_gen_q.pop_front();
          check_val("next_row", want.next_row, m_tdata[63:0]);
          check_val("born_mask", want.born_mask, m_tdata[127:64]);
          check_val("died_mask", want.died_mask, m_tdata[191:128]);
          check_val("row_index", 64'(want.row_index), 64'(m_tdata[203:192]));
          check_val("last_of_frame", 64'(want.last_of_frame), 64'(m_tlast));
        end
      end
    end
  end

  // result side: when rx_idle is set, drop ready for a random stall before each beat
  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_row(logic [llrs_pkg::ROW_W-1:0] cells);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cells;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent++;
  endtask

  // hold the row side until every queued beat is out, then settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(llrs_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_cfg(llrs_pkg::reg_idx_t idx, logic [31:0] val);
    stim_t s;
    s = '0;
    s.kind = STIM_CFG;
    s.idx  = idx;
    s.val  = val;
    dir_tab.push_back(s);
  endtask

  task automatic add_row(logic [llrs_pkg::ROW_W-1:0] cells);
    stim_t s;
    s = '0;
    s.kind  = STIM_ROW;
    s.cells = cells;
    dir_tab.push_back(s);
  endtask

  task automatic add_typed(logic [llrs_pkg::ROW_W-1:0] cells,
                           logic [llrs_pkg::ROW_W-1:0] nxt,
                           logic [llrs_pkg::ROW_W-1:0] born,
                           logic [llrs_pkg::ROW_W-1:0] died);
    stim_t s;
    s = '0;
    s.kind          = STIM_ROW;
    s.cells         = cells;
    s.res.on        = 1'b1;
    s.res.next_row  = nxt;
    s.res.born_mask = born;
    s.res.died_mask = died;
    dir_tab.push_back(s);
  endtask

  function automatic logic [llrs_pkg::ROW_W-1:0] draw_cells();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4:       return {$urandom, $urandom} | {$urandom, $urandom};
      5:       return 64'h7 << $urandom_range(0, 61);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    int n;
    int under_v;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    fail_cnt  = 0;
    rows_sent = 0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;

    // default rules, then the row count cut to one in the middle of a frame
    add_row(64'h0);
    add_row(64'h0000_0000_0000_0070);
    add_cfg(llrs_pkg::REG_GRID_ROWS, 1);
    add_row(64'h0000_0000_0000_0038);
    // single-row frames under the default rules
    add_typed('1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0, 64'h8000_0000_0000_0001);
    add_typed(64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA);
    add_typed(64'h0, 64'h0, 64'h0, 64'h0);
    // zero columns acts as one column
    add_cfg(llrs_pkg::REG_GRID_COLS, 0);
    add_typed('1, 64'h0, 64'h0, 64'h1);
    add_cfg(llrs_pkg::REG_GRID_COLS, 127);
    add_cfg(llrs_pkg::REG_GRID_ROWS, 0);
    add_cfg(llrs_pkg::REG_UNDER_LIMIT, 0);
    add_cfg(llrs_pkg::REG_OVER_LIMIT, 15);
    add_cfg(llrs_pkg::REG_BIRTH_COUNT, 0);
    add_typed(64'h0, '1, '1, 64'h0);
    // birth never matches: every cell keeps its state
    add_cfg(llrs_pkg::REG_BIRTH_COUNT, 15);
    add_typed(64'hDEAD_BEEF_0123_4567, 64'hDEAD_BEEF_0123_4567, 64'h0, 64'h0);
    // under limit above eight kills every cell
    add_cfg(llrs_pkg::REG_UNDER_LIMIT, 15);
    add_typed('1, 64'h0, 64'h0, '1);
    add_cfg(llrs_pkg::REG_UNDER_LIMIT, 0);
    add_cfg(llrs_pkg::REG_OVER_LIMIT, 0);
    add_cfg(llrs_pkg::REG_BIRTH_COUNT, 0);
    add_row('1);
    // row count beyond the maximum, then shrunk below the rows already seen
    add_cfg(llrs_pkg::REG_GRID_ROWS, 8191);
    add_cfg(llrs_pkg::REG_UNDER_LIMIT, 2);
    add_cfg(llrs_pkg::REG_OVER_LIMIT, 3);
    add_cfg(llrs_pkg::REG_BIRTH_COUNT, 3);
    add_row(64'h0);
    add_row(64'h0000_0000_0000_0E00);
    add_row(64'h0);
    add_cfg(llrs_pkg::REG_GRID_ROWS, 2);
    add_row(64'h8000_0000_0000_0003);
    // columns narrowed in the middle of a frame
    add_cfg(llrs_pkg::REG_GRID_ROWS, 4);
    add_row('1);
    add_row(64'hF0F0_F0F0_F0F0_F0F0);
    add_cfg(llrs_pkg::REG_GRID_COLS, 10);
    add_row('1);
    add_row(64'h0000_0000_0000_0155);
    add_cfg(llrs_pkg::REG_GRID_COLS, 1);
    add_cfg(llrs_pkg::REG_GRID_ROWS, 3);
    add_row('1);
    add_row('1);
    add_row('1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STIM_CFG) begin
        drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        typed_q.push_back(dir_tab[i].res);
        send_row(dir_tab[i].cells);
      end
    end

    while (rows_sent < ITEMS) begin
      drain();
      tx_idle = ($urandom_range(0, 9) < 7);
      rx_idle = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 15))
        0:       cfg_write(llrs_pkg::REG_GRID_COLS, 0);
        1:       cfg_write(llrs_pkg::REG_GRID_COLS, 1);
        2:       cfg_write(llrs_pkg::REG_GRID_COLS, 64);
        3:       cfg_write(llrs_pkg::REG_GRID_COLS, $urandom_range(65, 127));
        default: cfg_write(llrs_pkg::REG_GRID_COLS, $urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 15))
        0:       cfg_write(llrs_pkg::REG_GRID_ROWS, 0);
        1:       cfg_write(llrs_pkg::REG_GRID_ROWS, 1);
        2:       cfg_write(llrs_pkg::REG_GRID_ROWS, 8191);
        3:       cfg_write(llrs_pkg::REG_GRID_ROWS, $urandom_range(4096, 8190));
        4:       cfg_write(llrs_pkg::REG_GRID_ROWS, $urandom_range(13, 60));
        default: cfg_write(llrs_pkg::REG_GRID_ROWS, $urandom_range(2, 12));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(llrs_pkg::REG_UNDER_LIMIT, $urandom_range(0, 15));
        cfg_write(llrs_pkg::REG_OVER_LIMIT, $urandom_range(0, 15));
        cfg_write(llrs_pkg::REG_BIRTH_COUNT, $urandom_range(0, 15));
      end else begin
        under_v = $urandom_range(1, 3);
        cfg_write(llrs_pkg::REG_UNDER_LIMIT, under_v);
        cfg_write(llrs_pkg::REG_OVER_LIMIT, $urandom_range(under_v, 5));
        cfg_write(llrs_pkg::REG_BIRTH_COUNT, $urandom_range(2, 4));
      end
      n = $urandom_range(4, 60);
      repeat (n) send_row(draw_cells());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (fail_cnt == 0 && next_gen_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ life_like_automaton_row_step.f @@
hdl/llrs_pkg.sv
hdl/llrs_cell.sv
hdl/llrs_out_queue.sv
hdl/life_like_automaton_row_step.sv
dv/tb_life_like_automaton_row_step.sv
